// ===== sv/ncd_pkg.sv =====
`default_nettype none

package ncd_pkg;

  // Table geometry.
  localparam int NUM_CARS   = 8;
  localparam int IDX_W      = $clog2(NUM_CARS);
  localparam int CNT_W      = $clog2(NUM_CARS + 1);
  localparam int NUM_FLOORS = 64;
  localparam int FLOOR_W    = 6;
  // Stored floor carries a sign so that minus one can mean unknown.
  localparam int CFLOOR_W   = FLOOR_W + 1;
  localparam int DIFF_W     = FLOOR_W + 2;
  localparam int DIST_W     = FLOOR_W + 1;

  // Field and register widths.
  localparam int OP_W      = 2;
  localparam int HEAD_W    = 2;
  localparam int STOPS_W   = 8;
  localparam int WEIGHT_W  = 8;
  localparam int NCARS_W   = 4;
  localparam int LIMIT_W   = 18;
  localparam int FPROD_W   = WEIGHT_W + DIST_W;
  localparam int LPROD_W   = WEIGHT_W + STOPS_W;
  localparam int SCORE_W   = LPROD_W + 1;
  localparam int CFG_IDX_W = 2;

  localparam logic [STOPS_W-1:0] STOPS_MAX = {STOPS_W{1'b1}};

  // Input operation codes.
  typedef enum logic [OP_W-1:0] {
    OP_CALL    = 2'd0,
    OP_FLOOR   = 2'd1,
    OP_STOP    = 2'd2,
    OP_HEADING = 2'd3
  } op_t;

  // Travel direction codes; code 3 is stored but treated like idle.
  localparam logic [HEAD_W-1:0] HEAD_IDLE = 2'd0;
  localparam logic [HEAD_W-1:0] HEAD_UP   = 2'd1;
  localparam logic [HEAD_W-1:0] HEAD_DOWN = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_CARS     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_WEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOAD_WEIGHT  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COST_LIMIT   = 2'd3;

  // Request into the scoring unit: one table entry per beat.
  typedef struct packed {
    logic                       vld;
    logic [IDX_W-1:0]           idx;
    logic signed [CFLOOR_W-1:0] car_floor;
    logic [HEAD_W-1:0]          heading;
    logic [STOPS_W-1:0]         stops;
  } score_req_t;

  // Registered response from the scoring unit.
  typedef struct packed {
    logic               vld;
    logic               skip;
    logic [IDX_W-1:0]   idx;
    logic [SCORE_W-1:0] score;
  } score_rsp_t;

  // Saturate a floor number to the top floor of the building.
  function automatic logic [FLOOR_W-1:0] clamp_floor(input logic [FLOOR_W-1:0] f);
    logic [FLOOR_W:0] fx;
    fx = {1'b0, f};
    if (fx >= (FLOOR_W+1)'(NUM_FLOORS)) begin
      clamp_floor = FLOOR_W'(NUM_FLOORS - 1);
    end else begin
      clamp_floor = f;
    end
  endfunction

endpackage

`default_nettype wire

// ===== sv/nearest_car_dispatcher_top.sv =====
`default_nettype none

// Nearest-car dispatcher. Each beat on the in_ channel is either a call (op 0)
// or a status event for one car, and gives exactly one beat on the out_ channel.
// A call scans the cars in service one per cycle through a two-stage scoring
// unit (products registered, then sum and compare); the car with the lowest
// score below cost_limit wins, lowest index on ties, and its stop count rises.
// The cars in service number num_cars capped at eight. A call passes through the
// scan, drain and commit states to the result state (straight there when no car
// is in service), a status event through the event state; the item leaves the
// result state once the output register is free, and in_ready then rises.
// in_ready is high only while no item is in work, and the next item may be taken
// while a result still waits for out_ready. The cfg_ port is always ready and
// must be written only while the block is idle.
module nearest_car_dispatcher_top
  import ncd_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,

  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [OP_W-1:0]      in_op,
  input  wire logic [IDX_W-1:0]     in_car,
  input  wire logic [FLOOR_W-1:0]   in_floor,
  input  wire logic [HEAD_W-1:0]    in_heading,

  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      out_assigned,
  output logic [IDX_W-1:0]          out_chosen_car,
  output logic                      out_bad_car,

  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [LIMIT_W-1:0]   cfg_data
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_EVENT  = 6'b000010,
    S_SCAN   = 6'b000100,
    S_DRAIN  = 6'b001000,
    S_COMMIT = 6'b010000,
    S_RESULT = 6'b100000
  } state_t;

  state_t                     state_r, state_nxt;

  logic [NCARS_W-1:0]         num_cars_r;
  logic [WEIGHT_W-1:0]        floor_weight_r;
  logic [WEIGHT_W-1:0]        load_weight_r;
  logic [LIMIT_W-1:0]         cost_limit_r;

  op_t                        op_r;
  logic [FLOOR_W-1:0]         floor_r;
  logic [HEAD_W-1:0]          heading_r;
  logic [CNT_W-1:0]           count_r, count_nxt;
  logic [IDX_W-1:0]           idx_r, idx_nxt;
  logic                       found_r, found_nxt;
  logic [IDX_W-1:0]           best_r, best_nxt;
  logic [SCORE_W-1:0]         best_score_r, best_score_nxt;
  logic                       bad_r, bad_nxt;

  logic                       out_valid_r;
  logic                       out_assigned_r;
  logic [IDX_W-1:0]           out_chosen_r;
  logic                       out_bad_r;
  logic                       out_load;

  logic signed [CFLOOR_W-1:0] car_floor_r   [NUM_CARS];
  logic [HEAD_W-1:0]          car_heading_r [NUM_CARS];
  logic [STOPS_W-1:0]         car_stops_r   [NUM_CARS];

  logic signed [CFLOOR_W-1:0] rd_floor;
  logic [HEAD_W-1:0]          rd_heading;
  logic [STOPS_W-1:0]         rd_stops;
  logic                       in_beat;
  logic                       scan_last;
  logic                       event_wr;
  logic                       commit_wr;

  score_req_t                 sc_req;
  score_rsp_t                 sc_rsp;

  assign in_ready  = (state_r == S_IDLE);
  assign in_beat   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_cars_r     <= NCARS_W'(8);
      floor_weight_r <= WEIGHT_W'(1);
      load_weight_r  <= WEIGHT_W'(1);
      cost_limit_r   <= LIMIT_W'(256);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_NUM_CARS:     num_cars_r     <= cfg_data[NCARS_W-1:0];
        CFG_FLOOR_WEIGHT: floor_weight_r <= cfg_data[WEIGHT_W-1:0];
        CFG_LOAD_WEIGHT:  load_weight_r  <= cfg_data[WEIGHT_W-1:0];
        CFG_COST_LIMIT:   cost_limit_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Single read port into the car table, addressed by the sequencer index.
  assign rd_floor   = car_floor_r[idx_r];
  assign rd_heading = car_heading_r[idx_r];
  assign rd_stops   = car_stops_r[idx_r];

  assign sc_req.vld       = (state_r == S_SCAN);
  assign sc_req.idx       = idx_r;
  assign sc_req.car_floor = rd_floor;
  assign sc_req.heading   = rd_heading;
  assign sc_req.stops     = rd_stops;

  ncd_score u_score (
    .clk          (clk),
    .rst_n        (rst_n),
    .req          (sc_req),
    .target       (floor_r),
    .floor_weight (floor_weight_r),
    .load_weight  (load_weight_r),
    .rsp          (sc_rsp)
  );

  assign scan_last = ({{(CNT_W-IDX_W){1'b0}}, idx_r} == (count_r - CNT_W'(1)));
  assign out_load  = (state_r == S_RESULT) && (!out_valid_r || out_ready);

  // Sequencer and best-car tracking.
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    found_nxt      = found_r;
    best_nxt       = best_r;
    best_score_nxt = best_score_r;
    bad_nxt        = bad_r;

    // Compare stage: keep the lowest qualifying score, earliest car on ties.
    if (sc_rsp.vld && !sc_rsp.skip &&
        ({1'b0, sc_rsp.score} < cost_limit_r) &&
        (!found_r || (sc_rsp.score < best_score_r))) begin
      found_nxt      = 1'b1;
      best_nxt       = sc_rsp.idx;
      best_score_nxt = sc_rsp.score;
    end

    case (state_r)
      S_IDLE: begin
        if (in_beat) begin
          if (num_cars_r > NCARS_W'(NUM_CARS)) begin
            count_nxt = CNT_W'(NUM_CARS);
          end else begin
            count_nxt = CNT_W'(num_cars_r);
          end
          found_nxt = 1'b0;
          best_nxt  = '0;
          bad_nxt   = 1'b0;
          if (op_t'(in_op) == OP_CALL) begin
            idx_nxt = '0;
            if (count_nxt == '0) begin
              state_nxt = S_RESULT;
            end else begin
              state_nxt = S_SCAN;
            end
          end else begin
            idx_nxt   = in_car;
            state_nxt = S_EVENT;
          end
        end
      end
      S_EVENT: begin
        bad_nxt   = ({{(CNT_W-IDX_W){1'b0}}, idx_r} >= count_r);
        state_nxt = S_RESULT;
      end
      S_SCAN: begin
        if (scan_last) begin
          state_nxt = S_DRAIN;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      S_DRAIN: begin
        idx_nxt   = best_nxt;
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      found_r <= 1'b0;
      bad_r   <= 1'b0;
      count_r <= '0;
      idx_r   <= '0;
      best_r  <= '0;
    end else begin
      state_r <= state_nxt;
      found_r <= found_nxt;
      bad_r   <= bad_nxt;
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
      best_r  <= best_nxt;
    end
  end

  // Latched item and running best score.
  always_ff @(posedge clk) begin
    if (in_beat) begin
      op_r      <= op_t'(in_op);
      floor_r   <= clamp_floor(in_floor);
      heading_r <= in_heading;
    end
    best_score_r <= best_score_nxt;
  end

  // Car table writes all go to the sequencer index.
  assign event_wr  = (state_r == S_EVENT) &&
                     ({{(CNT_W-IDX_W){1'b0}}, idx_r} < count_r);
  assign commit_wr = (state_r == S_COMMIT) && found_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CARS; i++) begin
        car_floor_r[i]   <= '1;
        car_heading_r[i] <= HEAD_IDLE;
        car_stops_r[i]   <= '0;
      end
    end else if (event_wr) begin
      case (op_r)
        OP_FLOOR:   car_floor_r[idx_r] <= signed'({1'b0, floor_r});
        OP_STOP: begin
          if (rd_stops != '0) begin
            car_stops_r[idx_r] <= rd_stops - STOPS_W'(1);
          end
        end
        OP_HEADING: car_heading_r[idx_r] <= heading_r;
        default: ;
      endcase
    end else if (commit_wr) begin
      if (rd_stops != STOPS_MAX) begin
        car_stops_r[idx_r] <= rd_stops + STOPS_W'(1);
      end
    end
  end

  // Output register decouples the result from the next item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_assigned_r <= (op_r == OP_CALL) && found_r;
      out_chosen_r   <= ((op_r == OP_CALL) && found_r) ? best_r : '0;
      out_bad_r      <= bad_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_assigned   = out_assigned_r;
  assign out_chosen_car = out_chosen_r;
  assign out_bad_car    = out_bad_r;

`ifndef ASSERT_OFF
  // The scoring pipeline is empty whenever a new item can be taken.
  a_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !sc_rsp.vld)
    else $error("scoring pipeline busy while idle");

  // A winning car always lies within the cars in service.
  a_best_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    found_r |-> ({{(CNT_W-IDX_W){1'b0}}, best_r} < count_r))
    else $error("chosen car outside cars in service");

  // A placed call never carries the bad car flag.
  a_assigned_not_bad: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_assigned |-> !out_bad_car)
    else $error("assigned result flagged as bad car");

  // Without an assignment the chosen car reads as zero.
  a_chosen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_assigned |-> (out_chosen_car == '0))
    else $error("chosen car set without assignment");
`endif

endmodule

`default_nettype wire

// ===== sv/ncd_score.sv =====
`default_nettype none

// Scores one car per cycle: direction filter and distance in front of the
// product registers, the final sum behind them.
module ncd_score
  import ncd_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire score_req_t           req,
  input  wire logic [FLOOR_W-1:0]   target,
  input  wire logic [WEIGHT_W-1:0]  floor_weight,
  input  wire logic [WEIGHT_W-1:0]  load_weight,
  output score_rsp_t                rsp
);

  logic signed [DIFF_W-1:0] diff;
  logic [DIST_W-1:0]        span;
  logic                     skip;

  logic                     vld_r;
  logic                     skip_r;
  logic [IDX_W-1:0]         idx_r;
  logic [FPROD_W-1:0]       fprod_r;
  logic [LPROD_W-1:0]       lprod_r;

  // Signed distance from the car to the call; an unknown floor sits below floor zero.
  always_comb begin
    diff = signed'({2'b00, target}) - signed'({req.car_floor[CFLOOR_W-1], req.car_floor});
    skip = ((req.heading == HEAD_UP)   && (diff < 0)) ||
           ((req.heading == HEAD_DOWN) && (diff > 0));
    if (diff < 0) begin
      span = DIST_W'(-diff);
    end else begin
      span = DIST_W'(diff);
    end
  end

  // Valid pipeline bit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= req.vld;
    end
  end

  // Product registers.
  always_ff @(posedge clk) begin
    skip_r  <= skip;
    idx_r   <= req.idx;
    fprod_r <= FPROD_W'(floor_weight) * FPROD_W'(span);
    lprod_r <= LPROD_W'(load_weight) * LPROD_W'(req.stops);
  end

  assign rsp.vld   = vld_r;
  assign rsp.skip  = skip_r;
  assign rsp.idx   = idx_r;
  assign rsp.score = SCORE_W'(fprod_r) + SCORE_W'(lprod_r);

endmodule

`default_nettype wire
